FILE: rtl/rss_pkg.sv
// Shared types, constants and the key normalization function for the
// record sort and key search block. No dependencies.
package rss_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;
    localparam int TAG_W       = 32;
    localparam int KEY_BYTES   = KEY_W / 8;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SORT   = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        KIND_SORTED = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_NONE   = 2'd2,
        KIND_FULL   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WR_INPUT = 2'd0,
        WR_CUR   = 2'd1,
        WR_RD    = 2'd2
    } wr_src_t;

    typedef enum logic [1:0] {
        OUT_ZERO = 2'd0,
        OUT_RD   = 2'd1,
        OUT_CUR  = 2'd2
    } out_src_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        wr_src_t           wr_src;
        logic              cur_ld;
        logic              skey_ld;
        logic              out_ld;
        out_src_t          out_src;
        kind_t             out_kind;
        logic              out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } dp_sts_t;

    // Keep the top KEY_CHARS bytes and clear everything after the first zero byte.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic             alive;
        res   = '0;
        alive = 1'b1;
        for (int b = KEY_BYTES - 1; b >= 0; b--) begin
            if (b < KEY_BYTES - KEY_CHARS) alive = 1'b0;
            if (k[8*b +: 8] == 8'h00) alive = 1'b0;
            if (alive) res[8*b +: 8] = k[8*b +: 8];
        end
        return res;
    endfunction

endpackage

FILE: rtl/rss_dp.sv
// Datapath: record memories, read, carry and search-key registers, output register.
// Depends on rss_pkg; driven by rss_ctrl through dp_cmd_t.
module rss_dp (
    input  logic                     clk,
    input  rss_pkg::dp_cmd_t         cmd,
    output rss_pkg::dp_sts_t         sts,
    input  logic [rss_pkg::TAG_W-1:0] payload_tag,
    input  logic [rss_pkg::KEY_W-1:0] dest_key,
    output logic [1:0]               kind,
    output logic [rss_pkg::TAG_W-1:0] out_tag,
    output logic [rss_pkg::KEY_W-1:0] out_key,
    output logic                     last
);
    import rss_pkg::*;

    logic [KEY_W-1:0] key_mem [MAX_RECORDS];
    logic [TAG_W-1:0] tag_mem [MAX_RECORDS];

    logic [KEY_W-1:0] rd_key_reg, cur_key_reg, skey_reg, out_key_reg;
    logic [TAG_W-1:0] rd_tag_reg, cur_tag_reg, out_tag_reg;
    kind_t            out_kind_reg;
    logic             out_last_reg;

    logic [KEY_W-1:0] in_key_norm;
    logic [KEY_W-1:0] wr_key;
    logic [TAG_W-1:0] wr_tag;
    logic [KEY_W-1:0] out_key_next;
    logic [TAG_W-1:0] out_tag_next;

    assign in_key_norm = norm_key(dest_key);

    always_comb
    begin
        case (cmd.wr_src)
            WR_CUR:
            begin
                wr_key = cur_key_reg;
                wr_tag = cur_tag_reg;
            end
            WR_RD:
            begin
                wr_key = rd_key_reg;
                wr_tag = rd_tag_reg;
            end
            default:
            begin
                wr_key = in_key_norm;
                wr_tag = payload_tag;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.out_src)
            OUT_RD:
            begin
                out_key_next = rd_key_reg;
                out_tag_next = rd_tag_reg;
            end
            OUT_CUR:
            begin
                out_key_next = cur_key_reg;
                out_tag_next = cur_tag_reg;
            end
            default:
            begin
                out_key_next = '0;
                out_tag_next = '0;
            end
        endcase
    end

    // Single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[cmd.wr_addr] <= wr_key;
            tag_mem[cmd.wr_addr] <= wr_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_key_reg <= key_mem[cmd.rd_addr];
            rd_tag_reg <= tag_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_ld)
        begin
            cur_key_reg <= rd_key_reg;
            cur_tag_reg <= rd_tag_reg;
        end
        if (cmd.skey_ld)
        begin
            skey_reg <= in_key_norm;
        end
        if (cmd.out_ld)
        begin
            out_key_reg  <= out_key_next;
            out_tag_reg  <= out_tag_next;
            out_kind_reg <= cmd.out_kind;
            out_last_reg <= cmd.out_last;
        end
    end

    assign sts.gt  = (cur_key_reg > rd_key_reg);
    assign sts.eq  = (rd_key_reg == skey_reg);
    assign kind    = out_kind_reg;
    assign out_tag = out_tag_reg;
    assign out_key = out_key_reg;
    assign last    = out_last_reg;

endmodule

FILE: rtl/rss_ctrl.sv
// Controller: operation decode, record count, bubble sort, emit and search sequencer.
// Depends on rss_pkg; commands rss_dp through dp_cmd_t, reads dp_sts_t.
module rss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        operation,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output rss_pkg::dp_cmd_t  cmd,
    input  rss_pkg::dp_sts_t  sts
);
    import rss_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_NOTE      = 10'b00_0000_0010,
        S_SORT_LOAD = 10'b00_0000_0100,
        S_SORT_STEP = 10'b00_0000_1000,
        S_SORT_END  = 10'b00_0001_0000,
        S_EMIT_RD   = 10'b00_0010_0000,
        S_EMIT_WAIT = 10'b00_0100_0000,
        S_SRCH_RD   = 10'b00_1000_0000,
        S_SRCH_CHK  = 10'b01_0000_0000,
        S_SRCH_END  = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pass_end_reg, pass_end_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              found_reg, found_next;
    kind_t             note_kind_reg, note_kind_next;
    logic              out_valid_reg, out_valid_next;

    logic              slot_free;
    logic              advance;
    logic [ADDR_W-1:0] last_idx;

    assign slot_free = !out_valid_reg || !out_stall;
    assign last_idx  = ADDR_W'(count_reg - CNT_W'(1));
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pass_end_next  = pass_end_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        note_kind_next = note_kind_reg;
        advance        = 1'b1;
        cmd            = '0;
        cmd.wr_src     = WR_INPUT;
        cmd.out_src    = OUT_ZERO;
        cmd.out_kind   = KIND_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            if (count_reg == CNT_W'(MAX_RECORDS))
                            begin
                                note_kind_next = KIND_FULL;
                                state_next     = S_NOTE;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = count_reg[ADDR_W-1:0];
                                cmd.wr_src  = WR_INPUT;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                note_kind_next = KIND_NONE;
                                state_next     = S_NOTE;
                            end
                            else if (count_reg > CNT_W'(1))
                            begin
                                pass_end_next = last_idx;
                                cmd.rd_en     = 1'b1;
                                cmd.rd_addr   = '0;
                                state_next    = S_SORT_LOAD;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_EMIT_RD;
                            end
                        end
                        OP_SEARCH:
                        begin
                            cmd.skey_ld = 1'b1;
                            if (count_reg == '0)
                            begin
                                note_kind_next = KIND_NONE;
                                state_next     = S_NOTE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_NOTE:
            begin
                if (slot_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_src  = OUT_ZERO;
                    cmd.out_kind = note_kind_reg;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SORT_LOAD:
            begin
                // Entry 0 arrives: carry it, fetch entry 1
                cmd.cur_ld  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = ADDR_W'(1);
                j_next      = ADDR_W'(1);
                state_next  = S_SORT_STEP;
            end
            S_SORT_STEP:
            begin
                // Compare carried record with entry j; drop the smaller one at j-1
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = j_reg - ADDR_W'(1);
                if (sts.gt)
                begin
                    cmd.wr_src = WR_RD;
                end
                else
                begin
                    cmd.wr_src = WR_CUR;
                    cmd.cur_ld = 1'b1;
                end
                if (j_reg == pass_end_reg)
                begin
                    state_next = S_SORT_END;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = j_reg + ADDR_W'(1);
                    j_next      = j_reg + ADDR_W'(1);
                end
            end
            S_SORT_END:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = pass_end_reg;
                cmd.wr_src  = WR_CUR;
                if (pass_end_reg == ADDR_W'(1))
                begin
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    pass_end_next = pass_end_reg - ADDR_W'(1);
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr   = '0;
                    state_next    = S_SORT_LOAD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (slot_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_src  = OUT_RD;
                    cmd.out_kind = KIND_SORTED;
                    cmd.out_last = (idx_reg == last_idx);
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                // A match is held back until the next one shows it is not the last
                if (sts.eq)
                begin
                    if (found_reg)
                    begin
                        if (slot_free)
                        begin
                            cmd.out_ld   = 1'b1;
                            cmd.out_src  = OUT_CUR;
                            cmd.out_kind = KIND_MATCH;
                            cmd.out_last = 1'b0;
                        end
                        else
                        begin
                            advance = 1'b0;
                        end
                    end
                    if (advance)
                    begin
                        cmd.cur_ld = 1'b1;
                        found_next = 1'b1;
                    end
                end
                if (advance)
                begin
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_SRCH_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_END:
            begin
                if (slot_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_last = 1'b1;
                    if (found_reg)
                    begin
                        cmd.out_src  = OUT_CUR;
                        cmd.out_kind = KIND_MATCH;
                    end
                    else
                    begin
                        cmd.out_src  = OUT_ZERO;
                        cmd.out_kind = KIND_NONE;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pass_end_reg  <= '0;
            j_reg         <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            note_kind_reg <= KIND_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_end_reg  <= pass_end_next;
            j_reg         <= j_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            note_kind_reg <= note_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count above table depth");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> slot_free)
        else $error("output register loaded over an untaken result");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.wr_en) |-> (cmd.rd_addr != cmd.wr_addr))
        else $error("read and write hit the same entry in one cycle");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT_STEP) |-> (j_reg != '0 && j_reg <= pass_end_reg))
        else $error("sort index outside current pass");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation == OP_LOAD
         && count_reg != CNT_W'(MAX_RECORDS))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted load did not advance record count");

endmodule

FILE: rtl/record_sort_and_key_search.sv
// Top level of the record sort and key search block.
// Depends on rss_pkg, rss_ctrl and rss_dp.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | operation, payload_tag, dest_key        | in_valid / in_stall
//  output  | kind, out_tag, out_key, last            | out_valid / out_stall
//
// A load writes the record directly; a search reads and checks each stored record in turn,
// then sends its final result. A sort of n records runs passes p = n-1 down to 1, each a
// carry load, p compare-swaps at one per cycle through the record memory's one read and
// one write port, and a closing write; then each record is read and emitted in turn.
// Reset clears the record count and the control state; the memories keep no reset.
// Output stalls hold the sequencer in place; one transaction is accepted at a time.
module record_sort_and_key_search (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [rss_pkg::TAG_W-1:0] payload_tag,
    input  logic [rss_pkg::KEY_W-1:0] dest_key,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                kind,
    output logic [rss_pkg::TAG_W-1:0] out_tag,
    output logic [rss_pkg::KEY_W-1:0] out_key,
    output logic                      last
);
    import rss_pkg::*;

    // Command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer: decode the operation, walk the sort passes, emit and search
    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: record memories, carried record for bubbling, output register
    rss_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .sts         (sts),
        .payload_tag (payload_tag),
        .dest_key    (dest_key),
        .kind        (kind),
        .out_tag     (out_tag),
        .out_key     (out_key),
        .last        (last)
    );

endmodule

FILE: sim/record_table_checker.sv
// Checker for the record sort and key search block: watches both channels,
// keeps its own copy of the record table and compares every result.
// Depends on rss_pkg.
module record_table_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [rss_pkg::TAG_W-1:0] payload_tag,
    input  logic [rss_pkg::KEY_W-1:0] dest_key,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [1:0]                kind,
    input  logic [rss_pkg::TAG_W-1:0] out_tag,
    input  logic [rss_pkg::KEY_W-1:0] out_key,
    input  logic                      last,
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    typedef struct {
        kind_t            kind;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             last;
    } table_result_t;

    table_result_t    result_q[$];
    logic [KEY_W-1:0] table_keys[MAX_RECORDS];
    logic [TAG_W-1:0] table_tags[MAX_RECORDS];
    int               table_count;

    // Keep the top KEY_CHARS bytes up to the first zero byte.
    function automatic logic [KEY_W-1:0] terminate_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] trimmed;
        trimmed = '0;
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            if (raw[KEY_W-1-8*b -: 8] == 8'h00)
                break;
            trimmed[KEY_W-1-8*b -: 8] = raw[KEY_W-1-8*b -: 8];
        end
        return trimmed;
    endfunction

    task automatic push_result(input kind_t k, input logic [TAG_W-1:0] t,
                               input logic [KEY_W-1:0] key, input logic l);
        table_result_t r;
        r.kind = k;
        r.tag  = t;
        r.key  = key;
        r.last = l;
        result_q.push_back(r);
    endtask

    task automatic apply_operation(input logic [1:0] op, input logic [TAG_W-1:0] t,
                                   input logic [KEY_W-1:0] raw_key);
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] swap_key;
        logic [TAG_W-1:0] swap_tag;
        int               match_count;
        int               emitted;
        key = terminate_key(raw_key);
        case (op)
            OP_LOAD:
            begin
                if (table_count >= MAX_RECORDS)
                    push_result(KIND_FULL, '0, '0, 1'b1);
                else
                begin
                    table_keys[table_count] = key;
                    table_tags[table_count] = t;
                    table_count++;
                end
            end
            OP_SORT:
            begin
                if (table_count == 0)
                    push_result(KIND_NONE, '0, '0, 1'b1);
                else
                begin
                    // Swap only on strictly greater, so equal keys keep load order.
                    for (int p = 0; p + 1 < table_count; p++)
                        for (int j = 0; j + 1 < table_count - p; j++)
                            if (table_keys[j] > table_keys[j+1])
                            begin
                                swap_key        = table_keys[j];
                                swap_tag        = table_tags[j];
                                table_keys[j]   = table_keys[j+1];
                                table_tags[j]   = table_tags[j+1];
                                table_keys[j+1] = swap_key;
                                table_tags[j+1] = swap_tag;
                            end
                    for (int i = 0; i < table_count; i++)
                        push_result(KIND_SORTED, table_tags[i], table_keys[i],
                                    i + 1 == table_count);
                end
            end
            OP_SEARCH:
            begin
                match_count = 0;
                for (int i = 0; i < table_count; i++)
                    if (table_keys[i] == key)
                        match_count++;
                if (match_count == 0)
                    push_result(KIND_NONE, '0, '0, 1'b1);
                else
                begin
                    emitted = 0;
                    for (int i = 0; i < table_count; i++)
                        if (table_keys[i] == key)
                        begin
                            emitted++;
                            push_result(KIND_MATCH, table_tags[i], table_keys[i],
                                        emitted == match_count);
                        end
                end
            end
            default:
            begin
                // unused code: no result, table untouched
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            result_q.delete();
            table_count = 0;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            // Results first: nothing accepted on this edge can answer the input
            // accepted on the same edge.
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with none pending: kind %0d tag %h key %h last %0d",
                           kind, out_tag, out_key, last);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %h, actual %h", want.tag, out_tag);
                        fail_count++;
                    end
                    if (out_key !== want.key)
                    begin
                        $error("out_key: expected %h, actual %h", want.key, out_key);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_operation(operation, payload_tag, dest_key);
            outstanding <= result_q.size();
        end
    end

endmodule

FILE: sim/record_sort_and_key_search_tb.sv
// Testbench top for the record sort and key search block: clock, reset,
// stimulus, receiver stalls and the verdict.
// Depends on rss_pkg, record_sort_and_key_search and record_table_checker.
module record_sort_and_key_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS  = 255;
    localparam int         DRAIN_EVERY   = 60;
    // Margin for a trailing load to settle; kept generous.
    localparam int         SETTLE_CYCLES = 50;
    // Worst case is every item a full-table sort emitting 64 results, each
    // held by receiver stalls, plus sender gaps. Allow several times the
    // length of that run.
    localparam int         CYCLE_LIMIT   = 5_000_000;

    localparam logic [KEY_W-1:0] KEY_A = 64'h4100_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_B = 64'h4200_0000_0000_0000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } stall_pattern_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic [1:0]       operation   = OP_LOAD;
    logic [TAG_W-1:0] payload_tag = '0;
    logic [KEY_W-1:0] dest_key    = '0;
    logic             out_stall   = 1'b0;

    logic             in_stall;
    logic             out_valid;
    logic [1:0]       kind;
    logic [TAG_W-1:0] out_tag;
    logic [KEY_W-1:0] out_key;
    logic             last;

    int               fail_count;
    int               outstanding;
    int               cycle_count = 0;

    // Sender burst bookkeeping and what the table holds, for shaping stimulus.
    int               burst_left  = 0;
    int               loads_sent  = 0;
    logic [KEY_W-1:0] loaded_keys[$];

    // Receiver stall pattern state.
    stall_pattern_t   stall_pattern = STALL_NONE;
    int               pattern_left  = 0;
    int               run_left      = 0;
    logic             run_level     = 1'b0;

    record_sort_and_key_search DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .payload_tag(payload_tag),
        .dest_key   (dest_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_tag    (out_tag),
        .out_key    (out_key),
        .last       (last)
    );

    record_table_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .payload_tag(payload_tag),
        .dest_key   (dest_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_tag    (out_tag),
        .out_key    (out_key),
        .last       (last),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always #5 clk = ~clk;

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("record_sort_and_key_search regression: fail");
            $finish;
        end
    end

    // Receiver: switch at random between no stall, random stalls and long stall
    // runs so stalls land on every phase of a sort.
    always @(posedge clk)
    begin
        if (pattern_left == 0)
        begin
            stall_pattern = stall_pattern_t'($urandom_range(0, 2));
            pattern_left  = $urandom_range(50, 400);
        end
        pattern_left--;
        case (stall_pattern)
            STALL_NONE:
                out_stall <= 1'b0;
            STALL_RANDOM:
                out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_level = ~run_level;
                    run_left  = $urandom_range(1, 16);
                end
                run_left--;
                out_stall <= run_level;
            end
        endcase
    end

    // Drive one transaction and hold it until accepted. Open a new burst with
    // a random gap when the current one runs out; valid is only lowered
    // across a real gap, never dropped and raised on the same edge.
    task automatic send_item(input logic [1:0] op, input logic [TAG_W-1:0] tag,
                             input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        operation   <= op;
        payload_tag <= tag;
        dest_key    <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_LOAD && loads_sent < MAX_RECORDS)
        begin
            loaded_keys.push_back(key);
            loads_sent++;
        end
    endtask

    // Hold off the sender until every pending result is back, then let a
    // trailing load settle.
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keys in four flavors: fully random, short words from a tiny alphabet
    // (plenty of duplicates for stable-order checks), random with an embedded
    // terminator, and a stored key with junk written after its terminator.
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] junk;
        logic             zero_seen;
        int               len;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:
            begin
                // keep the fully random key
            end
            1:
            begin
                k   = '0;
                len = $urandom_range(1, 3);
                for (int b = 0; b < len; b++)
                    k[KEY_W-1-8*b -: 8] = 8'h41 + 8'($urandom_range(0, 2));
            end
            2:
                k[8*$urandom_range(0, KEY_BYTES-1) +: 8] = 8'h00;
            default:
            begin
                if (loaded_keys.size() != 0)
                begin
                    k         = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
                    junk      = {$urandom, $urandom};
                    zero_seen = 1'b0;
                    for (int b = KEY_BYTES - 1; b >= 0; b--)
                    begin
                        if (zero_seen)
                            k[8*b +: 8] = junk[8*b +: 8];
                        else if (k[8*b +: 8] == 8'h00)
                            zero_seen = 1'b1;
                    end
                end
            end
        endcase
        return k;
    endfunction

    // Searches mostly hit stored keys; the rest probe arbitrary keys.
    function automatic logic [KEY_W-1:0] search_key();
        logic [KEY_W-1:0] k;
        if (loaded_keys.size() != 0 && $urandom_range(0, 9) < 6)
            k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        else
            k = random_key();
        return k;
    endfunction

    initial
    begin
        int pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty table, extremes, terminators, duplicates.
        send_item(OP_SORT,   32'h0,        64'h0);                 // sort of empty table
        send_item(OP_SEARCH, 32'h0,        KEY_A);                 // search of empty table
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // ignored code
        send_item(OP_LOAD,   32'h0,        64'h0);                 // all-zero key
        send_item(OP_LOAD,   32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOAD,   32'h1234_5678, 64'h4142_0043_4445_4647); // junk after terminator
        send_item(OP_LOAD,   32'h0000_0001, KEY_B);
        send_item(OP_LOAD,   32'h0000_0002, KEY_A);
        send_item(OP_LOAD,   32'h0000_0003, KEY_B);                 // duplicate key
        send_item(OP_SEARCH, 32'hDEAD_BEEF, 64'h4142_00FF_FFFF_FFFF); // other junk, same key
        send_item(OP_SEARCH, 32'h0,        64'h5A5A_5A5A_5A5A_5A5A); // no match
        send_item(OP_SEARCH, 32'h0,        64'h00FF_FFFF_FFFF_FFFF); // leading zero: key 0
        send_item(OP_SEARCH, 32'h0,        KEY_B);                 // two matches in order
        send_item(OP_UNUSED, 32'hA5A5_A5A5, 64'h5A5A_5A5A_A5A5_A5A5);
        send_item(OP_SORT,   32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_SEARCH, 32'h0,        64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_SORT,   32'h0,        64'h0);                 // sort of sorted table
        wait_idle();

        // Random: fill the table gradually so most sorts run on partial
        // tables, then keep going on the full table with drops and searches.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (loads_sent < MAX_RECORDS)
            begin
                if (pick < 50)
                    send_item(OP_LOAD, $urandom, random_key());
                else if (pick < 86)
                    send_item(OP_SEARCH, $urandom, search_key());
                else if (pick < 96)
                    send_item(OP_SORT, $urandom, {$urandom, $urandom});
                else
                    send_item(OP_UNUSED, $urandom, {$urandom, $urandom});
            end
            else
            begin
                if (pick < 20)
                    send_item(OP_LOAD, $urandom, random_key());   // dropped: full
                else if (pick < 91)
                    send_item(OP_SEARCH, $urandom, search_key());
                else if (pick < 95)
                    send_item(OP_SORT, $urandom, {$urandom, $urandom});
                else
                    send_item(OP_UNUSED, $urandom, {$urandom, $urandom});
            end
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                wait_idle();
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("record_sort_and_key_search regression: pass");
        else
            $display("record_sort_and_key_search regression: fail");
        $finish;
    end

endmodule
